// ----- rtl/core/eavr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eavr_pkg
// Shared types and constants for the Euler-angle vector rotation block.
// ----------------------------------------------------------------------------
package eavr_pkg;

    localparam int TRIG_FRAC = 30;
    localparam int COEF_FRAC = 24;
    localparam int COEF_W    = 28;
    localparam int ANG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int RECIP_SH  = 39;
    localparam int RECIP_W   = 40;

    localparam longint HALF_PI   = 64'd1686629713;
    localparam longint RECIP_ONE = 64'sd1 <<< RECIP_SH;

    localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd3;

    localparam logic ORDER_XYZ = 1'b0;
    localparam logic ORDER_ZYX = 1'b1;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic                    order;
    } t_cfg;

    // ceil(2^39 / d): floor(x * m / 2^39) equals floor(x / d) for x below 2^31
    function automatic logic [RECIP_W-1:0] series_recip(input logic is_cos,
                                                        input logic [2:0] k);
        logic [RECIP_W-1:0] m;
        case ({is_cos, k})
            4'b0001: m = RECIP_W'((RECIP_ONE + 64'sd5) / 64'sd6);
            4'b0010: m = RECIP_W'((RECIP_ONE + 64'sd19) / 64'sd20);
            4'b0011: m = RECIP_W'((RECIP_ONE + 64'sd41) / 64'sd42);
            4'b0100: m = RECIP_W'((RECIP_ONE + 64'sd71) / 64'sd72);
            4'b0101: m = RECIP_W'((RECIP_ONE + 64'sd109) / 64'sd110);
            4'b0110: m = RECIP_W'((RECIP_ONE + 64'sd155) / 64'sd156);
            4'b1001: m = RECIP_W'((RECIP_ONE + 64'sd1) / 64'sd2);
            4'b1010: m = RECIP_W'((RECIP_ONE + 64'sd11) / 64'sd12);
            4'b1011: m = RECIP_W'((RECIP_ONE + 64'sd29) / 64'sd30);
            4'b1100: m = RECIP_W'((RECIP_ONE + 64'sd55) / 64'sd56);
            4'b1101: m = RECIP_W'((RECIP_ONE + 64'sd89) / 64'sd90);
            4'b1110: m = RECIP_W'((RECIP_ONE + 64'sd131) / 64'sd132);
            default: m = RECIP_W'(RECIP_ONE);
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/eavr_coef.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eavr_coef
// Sequencer that turns the angle registers into the Q24 rotation matrix:
// range reduction, Taylor series with a shared multiplier and reciprocal
// multiplication for the term divisors, quadrant mapping, then two 3x3
// matrix products.
// ----------------------------------------------------------------------------
module eavr_coef #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  eavr_pkg::t_cfg    i_cfg,
    output logic              o_busy,
    output eavr_pkg::t_coef   o_mat [9]
);

    localparam int AW   = 50 - ANGLE_FRAC_BITS;
    localparam int ASH  = eavr_pkg::TRIG_FRAC - ANGLE_FRAC_BITS;
    localparam longint KOFS =
        ((64'sd1 <<< (45 - ANGLE_FRAC_BITS)) / eavr_pkg::HALF_PI) + 1;
    localparam int KW   = $clog2(2 * KOFS + 2) + 1;
    localparam int RSH  = eavr_pkg::RECIP_SH - 16;
    localparam logic signed [AW-1:0] H_A   = AW'(eavr_pkg::HALF_PI);
    localparam logic signed [AW-1:0] HH_A  = AW'(eavr_pkg::HALF_PI / 2);
    localparam logic signed [AW-1:0] OFS_A =
        AW'(eavr_pkg::HALF_PI / 2 + KOFS * eavr_pkg::HALF_PI);
    localparam eavr_pkg::t_coef ONE = eavr_pkg::t_coef'(1 <<< eavr_pkg::COEF_FRAC);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RED, S_SQ, S_SQW, S_SQD, S_TM, S_TMW, S_TMD,
        S_DLW, S_DL, S_DHW, S_DH, S_DIVD, S_FIN, S_MI, S_MW, S_MA
    } t_state;

    t_state                 r_state;
    logic [1:0]             r_ang;
    logic signed [AW-1:0]   r_a;
    logic [KW-1:0]          r_k;
    logic [1:0]             r_quad;
    logic signed [31:0]     r_r;
    logic signed [31:0]     r_r2;
    logic signed [31:0]     r_t;
    logic signed [33:0]     r_sum;
    logic signed [33:0]     r_ssum;
    logic [2:0]             r_term;
    logic                   r_cos_ph;
    logic signed [31:0]     r_ma;
    logic signed [31:0]     r_mb;
    logic signed [63:0]     r_mp;
    logic                   r_dneg;
    logic [30:0]            r_dlo;
    logic [30:0]            r_dq;
    eavr_pkg::t_coef        r_sin [3];
    eavr_pkg::t_coef        r_cos [3];
    eavr_pkg::t_coef        r_tm  [9];
    eavr_pkg::t_coef        r_m   [9];
    logic signed [63:0]     r_acc;
    logic [1:0]             r_i;
    logic [1:0]             r_j;
    logic [1:0]             r_kk;
    logic                   r_pass;

    logic signed [15:0]     w_ang;
    logic signed [AW-1:0]   w_a;
    logic signed [31:0]     w_x;
    logic [30:0]            w_xabs;
    logic [eavr_pkg::RECIP_W-1:0] w_m;
    logic signed [31:0]     w_tq;
    logic signed [33:0]     n_sum;
    eavr_pkg::t_coef        w_s0;
    eavr_pkg::t_coef        w_c0;
    eavr_pkg::t_coef        w_ex [9];
    eavr_pkg::t_coef        w_ey [9];
    eavr_pkg::t_coef        w_ez [9];
    eavr_pkg::t_coef        w_ae;
    eavr_pkg::t_coef        w_be;
    logic [3:0]             w_ai;
    logic [3:0]             w_bi;
    logic [3:0]             w_oi;
    logic signed [63:0]     n_acc;
    eavr_pkg::t_coef        w_elem;

    always_comb begin
        case (r_ang)
            2'd0:    w_ang = i_cfg.roll;
            2'd1:    w_ang = i_cfg.pitch;
            default: w_ang = i_cfg.yaw;
        endcase
    end

    assign w_a    = AW'(w_ang) <<< ASH;
    assign w_x    = 32'(-((r_mp + 64'sd536870912) >>> eavr_pkg::TRIG_FRAC));
    assign w_xabs = w_x[31] ? 31'(-w_x) : w_x[30:0];
    assign w_m    = eavr_pkg::series_recip(r_cos_ph, r_term);
    assign w_tq   = r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    assign n_sum  = r_sum + 34'(w_tq);
    assign w_s0   = eavr_pkg::t_coef'((r_ssum + 34'sd32) >>> 6);
    assign w_c0   = eavr_pkg::t_coef'((r_sum + 34'sd32) >>> 6);

    assign w_ex = '{ONE, '0, '0,  '0, r_cos[0], -r_sin[0],  '0, r_sin[0], r_cos[0]};
    assign w_ey = '{r_cos[1], '0, r_sin[1],  '0, ONE, '0,  -r_sin[1], '0, r_cos[1]};
    assign w_ez = '{r_cos[2], -r_sin[2], '0,  r_sin[2], r_cos[2], '0,  '0, '0, ONE};

    assign w_ai = 4'(r_i) * 4'd3 + 4'(r_kk);
    assign w_bi = 4'(r_kk) * 4'd3 + 4'(r_j);
    assign w_oi = 4'(r_i) * 4'd3 + 4'(r_j);

    always_comb begin
        if (!r_pass) begin
            w_ae = (i_cfg.order == eavr_pkg::ORDER_ZYX) ? w_ez[w_ai] : w_ex[w_ai];
            w_be = w_ey[w_bi];
        end else begin
            w_ae = r_tm[w_ai];
            w_be = (i_cfg.order == eavr_pkg::ORDER_ZYX) ? w_ex[w_bi] : w_ez[w_bi];
        end
    end

    assign n_acc  = r_acc + r_mp;
    assign w_elem = eavr_pkg::t_coef'((n_acc + 64'sd8388608) >>> eavr_pkg::COEF_FRAC);

    always_ff @(posedge i_clk) begin
        r_mp <= r_ma * r_mb;
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_ang   <= '0;
        end else if (i_go) begin
            r_state <= S_LOAD;
            r_ang   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_state <= S_IDLE;
                end
                S_LOAD: begin
                    r_a     <= w_a + OFS_A;
                    r_k     <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (r_a >= H_A) begin
                        r_a <= r_a - H_A;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_r     <= 32'(r_a - HH_A);
                        r_quad  <= 2'(r_k) - 2'(KOFS);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_ma    <= r_r;
                    r_mb    <= r_r;
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    r_state <= S_SQD;
                end
                S_SQD: begin
                    r_r2     <= 32'((r_mp + 64'sd536870912) >>> eavr_pkg::TRIG_FRAC);
                    r_t      <= r_r;
                    r_sum    <= 34'(r_r);
                    r_term   <= 3'd1;
                    r_cos_ph <= 1'b0;
                    r_state  <= S_TM;
                end
                S_TM: begin
                    r_ma    <= r_t;
                    r_mb    <= r_r2;
                    r_state <= S_TMW;
                end
                S_TMW: begin
                    r_state <= S_TMD;
                end
                S_TMD: begin
                    r_dneg  <= w_x[31];
                    r_ma    <= $signed({1'b0, w_xabs});
                    r_mb    <= $signed({16'd0, w_m[15:0]});
                    r_state <= S_DLW;
                end
                S_DLW: begin
                    r_state <= S_DL;
                end
                S_DL: begin
                    r_dlo   <= r_mp[46:16];
                    r_mb    <= $signed({8'd0, w_m[eavr_pkg::RECIP_W-1:16]});
                    r_state <= S_DHW;
                end
                S_DHW: begin
                    r_state <= S_DH;
                end
                S_DH: begin
                    r_dq    <= 31'((r_mp + $signed({33'd0, r_dlo})) >>> RSH);
                    r_state <= S_DIVD;
                end
                S_DIVD: begin
                    if (r_term == 3'd6) begin
                        if (!r_cos_ph) begin
                            r_ssum   <= n_sum;
                            r_t      <= 32'sd1073741824;
                            r_sum    <= 34'sd1073741824;
                            r_term   <= 3'd1;
                            r_cos_ph <= 1'b1;
                            r_state  <= S_TM;
                        end else begin
                            r_sum   <= n_sum;
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_t     <= w_tq;
                        r_sum   <= n_sum;
                        r_term  <= r_term + 1'b1;
                        r_state <= S_TM;
                    end
                end
                S_FIN: begin
                    case (r_quad)
                        2'd0: begin
                            r_sin[r_ang] <= w_s0;
                            r_cos[r_ang] <= w_c0;
                        end
                        2'd1: begin
                            r_sin[r_ang] <= w_c0;
                            r_cos[r_ang] <= -w_s0;
                        end
                        2'd2: begin
                            r_sin[r_ang] <= -w_s0;
                            r_cos[r_ang] <= -w_c0;
                        end
                        default: begin
                            r_sin[r_ang] <= -w_c0;
                            r_cos[r_ang] <= w_s0;
                        end
                    endcase
                    if (r_ang == 2'd2) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_kk    <= '0;
                        r_acc   <= '0;
                        r_pass  <= 1'b0;
                        r_state <= S_MI;
                    end else begin
                        r_ang   <= r_ang + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_MI: begin
                    r_ma    <= 32'(w_ae);
                    r_mb    <= 32'(w_be);
                    r_state <= S_MW;
                end
                S_MW: begin
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_state <= S_MI;
                    if (r_kk == 2'd2) begin
                        if (!r_pass) begin
                            r_tm[w_oi] <= w_elem;
                        end else begin
                            r_m[w_oi] <= w_elem;
                        end
                        r_acc <= '0;
                        r_kk  <= '0;
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            if (r_i == 2'd2) begin
                                r_i    <= '0;
                                r_pass <= 1'b1;
                                if (r_pass) begin
                                    r_state <= S_IDLE;
                                end
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_acc <= n_acc;
                        r_kk  <= r_kk + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_mat  = r_m;

endmodule

// ----- rtl/core/euler_angle_vector_rotation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angle_vector_rotation_top
// Rotates vectors by the matrix built from roll, pitch and yaw registers.
// An accepted vector passes the five pipeline registers r1 to r5 before o_done;
// one vector per cycle while busy is low. The receiver cannot stall.
// After reset and after each write to register index 0 to 3, busy stays high
// while the matrix sequencer runs, mostly in the series terms.
// Reset (synchronous, active low) clears valids and loads register defaults.
// ----------------------------------------------------------------------------
module euler_angle_vector_rotation_top #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int VEC_WIDTH       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [eavr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [eavr_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic signed [VEC_WIDTH-1:0]         i_vec_x,
    input  logic signed [VEC_WIDTH-1:0]         i_vec_y,
    input  logic signed [VEC_WIDTH-1:0]         i_vec_z,
    output logic                                o_done,
    output logic signed [VEC_WIDTH-1:0]         o_out_x,
    output logic signed [VEC_WIDTH-1:0]         o_out_y,
    output logic signed [VEC_WIDTH-1:0]         o_out_z
);

    localparam int LO  = VEC_WIDTH / 2;
    localparam int HI  = VEC_WIDTH - LO;
    localparam int E   = eavr_pkg::COEF_W;
    localparam int PHW = E + HI;
    localparam int PLW = E + LO + 1;
    localparam int AHW = PHW + 2;
    localparam int ALW = PLW + 2;
    localparam int TW  = E + VEC_WIDTH + 4;
    localparam logic signed [TW-1:0] RND  = TW'(1) <<< (eavr_pkg::COEF_FRAC - 1);
    localparam logic signed [TW-1:0] VMAX =
        {{(TW - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [TW-1:0] VMIN = ~VMAX;

    eavr_pkg::t_cfg           r_cfg;
    logic                     w_go;
    logic                     w_accept;
    eavr_pkg::t_coef          w_mat [9];

    logic                     r1_v;
    logic                     r1_cmd;
    logic signed [VEC_WIDTH-1:0] r1_vec [3];
    logic                     r2_v;
    logic signed [PHW-1:0]    r2_ph [9];
    logic signed [PLW-1:0]    r2_pl [9];
    logic                     r3_v;
    logic signed [AHW-1:0]    r3_ah [3];
    logic signed [ALW-1:0]    r3_al [3];
    logic                     r4_v;
    logic signed [TW-1:0]     r4_tot [3];
    logic                     r5_v;
    logic signed [VEC_WIDTH-1:0] r5_out [3];

    eavr_pkg::t_coef          w_e [9];
    logic signed [HI-1:0]     w_vh [3];
    logic signed [LO:0]       w_vl [3];
    logic signed [TW-1:0]     w_sh [3];

    assign w_accept = start && !busy;
    assign w_go     = i_cfg_we && (i_cfg_idx <= eavr_pkg::REG_ORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roll  <= '0;
            r_cfg.pitch <= '0;
            r_cfg.yaw   <= '0;
            r_cfg.order <= eavr_pkg::ORDER_ZYX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                eavr_pkg::REG_ROLL:  r_cfg.roll  <= i_cfg_data;
                eavr_pkg::REG_PITCH: r_cfg.pitch <= i_cfg_data;
                eavr_pkg::REG_YAW:   r_cfg.yaw   <= i_cfg_data;
                eavr_pkg::REG_ORDER: r_cfg.order <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    eavr_coef #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_cfg   (r_cfg),
        .o_busy  (busy),
        .o_mat   (w_mat)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_e[i*3+j] = r1_cmd ? w_mat[j*3+i] : w_mat[i*3+j];
            end
            w_vh[i] = r1_vec[i][VEC_WIDTH-1:LO];
            w_vl[i] = $signed({1'b0, r1_vec[i][LO-1:0]});
            w_sh[i] = r4_tot[i] >>> eavr_pkg::COEF_FRAC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= w_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
        r1_cmd    <= i_cmd;
        r1_vec[0] <= i_vec_x;
        r1_vec[1] <= i_vec_y;
        r1_vec[2] <= i_vec_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r2_ph[i*3+j] <= w_e[i*3+j] * w_vh[j];
                r2_pl[i*3+j] <= w_e[i*3+j] * w_vl[j];
            end
            r3_ah[i]  <= AHW'(r2_ph[i*3]) + AHW'(r2_ph[i*3+1]) + AHW'(r2_ph[i*3+2]);
            r3_al[i]  <= ALW'(r2_pl[i*3]) + ALW'(r2_pl[i*3+1]) + ALW'(r2_pl[i*3+2]);
            r4_tot[i] <= (TW'(r3_ah[i]) <<< LO) + TW'(r3_al[i]) + RND;
            if (w_sh[i] > VMAX) begin
                r5_out[i] <= VMAX[VEC_WIDTH-1:0];
            end else if (w_sh[i] < VMIN) begin
                r5_out[i] <= VMIN[VEC_WIDTH-1:0];
            end else begin
                r5_out[i] <= w_sh[i][VEC_WIDTH-1:0];
            end
        end
    end

    assign o_done  = r5_v;
    assign o_out_x = r5_out[0];
    assign o_out_y = r5_out[1];
    assign o_out_z = r5_out[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_done)
        else $error("transfer did not complete after pipeline latency");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> busy)
        else $error("register write did not restart matrix build");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r3_v, 2))
        else $error("result without a transfer");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for euler_angle_vector_rotation_top. Programs roll,
// pitch, yaw and composition order, streams vectors in both directions and
// checks every rotated, saturated result against a bit-exact fixed-point
// predictor of the sine/cosine series, matrix build and vector product.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  AFB       = 13;
    localparam int  VW        = 32;
    localparam int  LATENCY   = 5;
    localparam int  N_PHASES  = 8;
    localparam int  PHASE_LEN = 65;
    localparam logic CMD_FWD  = 1'b0;
    localparam logic CMD_REV  = 1'b1;

    typedef struct {
        logic [VW-1:0] x;
        logic [VW-1:0] y;
        logic [VW-1:0] z;
    } t_rot_vec;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [eavr_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [eavr_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_cmd = 1'b0;
    logic signed [VW-1:0]           i_vec_x = '0;
    logic signed [VW-1:0]           i_vec_y = '0;
    logic signed [VW-1:0]           i_vec_z = '0;
    logic                           o_done;
    logic signed [VW-1:0]           o_out_x;
    logic signed [VW-1:0]           o_out_y;
    logic signed [VW-1:0]           o_out_z;

    logic [15:0] cur_roll, cur_pitch, cur_yaw;
    logic        cur_order;
    longint      rot_mat[3][3];
    t_rot_vec    pending_rot[$];
    int          n_errors = 0;

    euler_angle_vector_rotation_top #(
        .ANGLE_FRAC_BITS(AFB),
        .VEC_WIDTH(VW)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_vec_x(i_vec_x), .i_vec_y(i_vec_y), .i_vec_z(i_vec_z),
        .o_done(o_done), .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic void sin_cos_q24(input logic [15:0] ang, output longint s,
                                        output longint c);
        longint a, n, q, r, r2, t, ss, cc, s0, c0;
        a  = longint'($signed(ang)) * (longint'(1) <<< (eavr_pkg::TRIG_FRAC - AFB));
        n  = a + eavr_pkg::HALF_PI / 2;
        q  = n / eavr_pkg::HALF_PI;
        if (n % eavr_pkg::HALF_PI < 0)
            q = q - 1;
        r  = a - q * eavr_pkg::HALF_PI;
        r2 = rnd_shift(r * r, eavr_pkg::TRIG_FRAC);
        t  = r;
        ss = r;
        for (int k = 1; k <= 6; k++) begin
            t  = -rnd_shift(t * r2, eavr_pkg::TRIG_FRAC) / longint'((2 * k) * (2 * k + 1));
            ss = ss + t;
        end
        t  = longint'(1) <<< eavr_pkg::TRIG_FRAC;
        cc = t;
        for (int k = 1; k <= 6; k++) begin
            t  = -rnd_shift(t * r2, eavr_pkg::TRIG_FRAC) / longint'((2 * k - 1) * (2 * k));
            cc = cc + t;
        end
        s0 = rnd_shift(ss, eavr_pkg::TRIG_FRAC - eavr_pkg::COEF_FRAC);
        c0 = rnd_shift(cc, eavr_pkg::TRIG_FRAC - eavr_pkg::COEF_FRAC);
        case (q[1:0])
            2'd0: begin s = s0;  c = c0;  end
            2'd1: begin s = c0;  c = -s0; end
            2'd2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endfunction

    function automatic void rebuild_rotation();
        longint one, sx, cx, sy, cy, sz, cz, acc;
        longint mx[3][3], my[3][3], mz[3][3], pa[3][3], pb[3][3], tmp[3][3];
        one = longint'(1) <<< eavr_pkg::COEF_FRAC;
        sin_cos_q24(cur_roll, sx, cx);
        sin_cos_q24(cur_pitch, sy, cy);
        sin_cos_q24(cur_yaw, sz, cz);
        mx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        my = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
        mz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
        if (cur_order == eavr_pkg::ORDER_ZYX) begin
            pa = mz;
            pb = mx;
        end else begin
            pa = mx;
            pb = mz;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += pa[i][k] * my[k][j];
                tmp[i][j] = rnd_shift(acc, eavr_pkg::COEF_FRAC);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += tmp[i][k] * pb[k][j];
                rot_mat[i][j] = rnd_shift(acc, eavr_pkg::COEF_FRAC);
            end
    endfunction

    function automatic t_rot_vec rotate_vector(input logic cmd, input logic [VW-1:0] vx,
                                               input logic [VW-1:0] vy,
                                               input logic [VW-1:0] vz);
        longint vh[3], vl[3], v, e, acc_hi, acc_lo, res, vmax, vmin;
        logic [VW-1:0] o[3];
        t_rot_vec rv;
        vmax = (longint'(1) <<< (VW - 1)) - 1;
        vmin = -vmax - 1;
        for (int j = 0; j < 3; j++) begin
            v = longint'($signed(j == 0 ? vx : (j == 1 ? vy : vz)));
            vh[j] = v >>> eavr_pkg::COEF_FRAC;
            vl[j] = v - (vh[j] <<< eavr_pkg::COEF_FRAC);
        end
        for (int i = 0; i < 3; i++) begin
            acc_hi = 0;
            acc_lo = 0;
            for (int j = 0; j < 3; j++) begin
                e = (cmd == CMD_REV) ? rot_mat[j][i] : rot_mat[i][j];
                acc_hi += e * vh[j];
                acc_lo += e * vl[j];
            end
            res = acc_hi + rnd_shift(acc_lo, eavr_pkg::COEF_FRAC);
            if (res > vmax) res = vmax;
            if (res < vmin) res = vmin;
            o[i] = res[VW-1:0];
        end
        rv.x = o[0];
        rv.y = o[1];
        rv.z = o[2];
        return rv;
    endfunction

    always @(posedge i_clk) begin
        t_rot_vec exp_rot;
        if (i_rst_n && o_done) begin
            if (pending_rot.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected transfer: %h %h %h", o_out_x, o_out_y, o_out_z);
            end else begin
                exp_rot = pending_rot.pop_front();
                if (o_out_x !== exp_rot.x || o_out_y !== exp_rot.y
                        || o_out_z !== exp_rot.z) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp %h %h %h got %h %h %h",
                                 exp_rot.x, exp_rot.y, exp_rot.z,
                                 o_out_x, o_out_y, o_out_z);
                end
            end
        end
    end

    // Hold start high until the transfer; leave it high for back-to-back items.
    task automatic send_vector(input logic cmd, input logic [VW-1:0] vx,
                               input logic [VW-1:0] vy, input logic [VW-1:0] vz);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_vec_x <= vx;
        i_vec_y <= vy;
        i_vec_z <= vz;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_rot.push_back(rotate_vector(cmd, vx, vy, vz));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rot.size() != 0)
            @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [eavr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            eavr_pkg::REG_ROLL:  cur_roll  = data;
            eavr_pkg::REG_PITCH: cur_pitch = data;
            eavr_pkg::REG_YAW:   cur_yaw   = data;
            eavr_pkg::REG_ORDER: cur_order = data[0];
            default: ;
        endcase
        rebuild_rotation();
    endtask

    task automatic program_angles(input logic [15:0] r, input logic [15:0] p,
                                  input logic [15:0] y, input logic [15:0] ord);
        drain();
        write_reg(eavr_pkg::REG_ROLL, r);
        write_reg(eavr_pkg::REG_PITCH, p);
        write_reg(eavr_pkg::REG_YAW, y);
        write_reg(eavr_pkg::REG_ORDER, ord);
    endtask

    function automatic logic [VW-1:0] rand_component();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return VW'($signed($urandom_range(0, 2 ** 21)) - (2 ** 20));
            2: return VW'($signed($urandom_range(0, 2 ** 30)) - (2 ** 29));
            default: return $urandom_range(0, 1) ? {1'b0, {(VW-1){1'b1}}}
                                                 : {1'b1, {(VW-1){1'b0}}};
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_vector(CMD_FWD, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000);
        send_vector(CMD_REV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_vector(CMD_FWD, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA);
    endtask

    task automatic test_angle_extremes();
        program_angles(16'h7FFF, 16'h8000, 16'h3243, {15'd0, eavr_pkg::ORDER_XYZ});
        send_vector(CMD_FWD, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_vector(CMD_REV, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        send_vector(CMD_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vector(CMD_REV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        program_angles(16'h8000, 16'h7FFF, 16'hCDBD, {15'd0, eavr_pkg::ORDER_ZYX});
        send_vector(CMD_FWD, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_vector(CMD_REV, 32'hAAAA_5555, 32'h1234_5678, 32'hEDCB_A988);
    endtask

    task automatic test_masking_and_bad_index();
        program_angles(16'h0C91, 16'hF36F, 16'h1922, 16'hFFFE);
        for (int k = 1; k <= 4; k++)
            write_reg(eavr_pkg::CFG_IDX_W'(eavr_pkg::REG_ORDER + k), 16'hFFFF);
        send_vector(CMD_FWD, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_vector(CMD_REV, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
    endtask

    task automatic test_saturation();
        program_angles(16'h1922, 16'h1922, 16'h1922, {15'd0, eavr_pkg::ORDER_XYZ});
        send_vector(CMD_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vector(CMD_REV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(CMD_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vector(CMD_REV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_random_stream();
        logic [15:0] ang[3];
        for (int ph = 0; ph < N_PHASES; ph++) begin
            for (int a = 0; a < 3; a++)
                case ($urandom_range(0, 3))
                    0: ang[a] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    1: ang[a] = '0;
                    default: ang[a] = $urandom;
                endcase
            program_angles(ang[0], ang[1], ang[2], 16'($urandom));
            for (int i = 0; i < PHASE_LEN; i++) begin
                send_vector(1'($urandom), rand_component(), rand_component(),
                            rand_component());
                if (ph == 2 && i == PHASE_LEN / 2)
                    drain();
                else if (ph != 3 && $urandom_range(0, 99) < 24)
                    idle_cycles($urandom_range(1, 4));
            end
        end
    endtask

    initial begin
        #(20 * 400000);
        $display("** euler_angle_vector_rotation_top: FAILED **");
        $finish;
    end

    initial begin
        cur_roll  = '0;
        cur_pitch = '0;
        cur_yaw   = '0;
        cur_order = eavr_pkg::ORDER_ZYX;
        rebuild_rotation();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_angle_extremes();
        test_masking_and_bad_index();
        test_saturation();
        test_random_stream();
        drain();
        if (n_errors == 0)
            $display("** euler_angle_vector_rotation_top: PASSED **");
        else
            $display("** euler_angle_vector_rotation_top: FAILED **");
        $finish;
    end
endmodule
